// ===== hw/rtl/bgs_pkg.sv =====
`default_nettype none

package bgs_pkg;

    localparam int unsigned ROW_W   = 8;   // source row width
    localparam int unsigned OUT_W   = 32;  // magnified row width
    localparam int unsigned SUB_MAX = 4;   // largest sub-row / sub-column count
    localparam int unsigned Q_DEPTH = 4;   // row job queue depth
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [2:0] SCALE_MIN  = 3'd1;
    localparam logic [2:0] SCALE_EPX2 = 3'd2;
    localparam logic [2:0] SCALE_EPX3 = 3'd3;
    localparam logic [2:0] SCALE_MAX  = 3'd4;

    typedef logic [2:0] t_scale;

    // one centre row to magnify, with its neighbors
    typedef struct packed {
        logic [ROW_W-1:0] above;
        logic [ROW_W-1:0] centre;
        logic [ROW_W-1:0] below;
        logic             final_row;
    } t_job;

    // sub-row selection shared by all lanes
    typedef struct packed {
        t_scale     scale;
        logic [1:0] sy;
    } t_sub;

    // zero reads as 1, above 4 saturates to 4
    function automatic t_scale eff_scale(input t_scale s);
        t_scale r;
        r = s;
        if (s < SCALE_MIN) begin
            r = SCALE_MIN;
        end else if (s > SCALE_MAX) begin
            r = SCALE_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bgs_lane.sv =====
`default_nettype none

// One source pixel: gives the sx pixels of sub-row sy of its block.
// Neighbor triples are {left, middle, right}.
module bgs_lane (
    input  wire logic [2:0]    i_above,
    input  wire logic [2:0]    i_centre,
    input  wire logic [2:0]    i_below,
    input  wire bgs_pkg::t_sub i_sub,
    output logic      [3:0]    o_px
);
    import bgs_pkg::*;

    logic a_p, b_p, c_p, d_p, e_p, f_p, g_p, h_p, i_p;
    logic db, bf, hd, fh;
    logic [8:0] o;

    assign {a_p, b_p, c_p} = i_above;
    assign {d_p, e_p, f_p} = i_centre;
    assign {g_p, h_p, i_p} = i_below;

    assign db = (d_p == b_p) && (d_p != h_p) && (b_p != f_p);
    assign bf = (b_p == f_p) && (b_p != d_p) && (f_p != h_p);
    assign hd = (h_p == d_p) && (h_p != f_p) && (d_p != b_p);
    assign fh = (f_p == h_p) && (f_p != b_p) && (h_p != d_p);

    always_comb begin
        o = {9{e_p}};
        if (i_sub.scale == SCALE_EPX2) begin
            if (db) o[0] = d_p;
            if (bf) o[1] = f_p;
            if (hd) o[2] = d_p;
            if (fh) o[3] = f_p;
        end else begin
            if (db) o[0] = d_p;
            if ((db && e_p != c_p) || (bf && e_p != a_p)) o[1] = b_p;
            if (bf) o[2] = f_p;
            if ((hd && e_p != a_p) || (db && e_p != g_p)) o[3] = d_p;
            if ((bf && e_p != i_p) || (fh && e_p != c_p)) o[5] = f_p;
            if (hd) o[6] = d_p;
            if ((fh && e_p != g_p) || (hd && e_p != i_p)) o[7] = h_p;
            if (fh) o[8] = f_p;
        end
    end

    always_comb begin
        o_px = {4{e_p}};
        unique case (i_sub.scale)
            SCALE_EPX2: begin
                o_px[1:0] = i_sub.sy[0] ? o[3:2] : o[1:0];
            end
            SCALE_EPX3: begin
                unique case (i_sub.sy)
                    2'd0:    o_px[2:0] = o[2:0];
                    2'd1:    o_px[2:0] = o[5:3];
                    default: o_px[2:0] = o[8:6];
                endcase
            end
            default: begin
                o_px = {4{e_p}};
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bgs_merge.sv =====
`default_nettype none

// Packs the lane pixels into one output row, leftmost pixel in the highest used bit.
module bgs_merge #(
    parameter int unsigned GW = 8
) (
    input  wire logic [GW-1:0][3:0]          i_px,
    input  wire bgs_pkg::t_scale             i_scale,
    output logic      [bgs_pkg::OUT_W-1:0]   o_row
);
    import bgs_pkg::*;

    always_comb begin
        o_row = '0;
        unique case (i_scale)
            SCALE_MIN: begin
                for (int gx = 0; gx < GW; gx++) begin
                    o_row[GW-1-gx] = i_px[gx][0];
                end
            end
            SCALE_EPX2: begin
                for (int gx = 0; gx < GW; gx++) begin
                    for (int sx = 0; sx < 2; sx++) begin
                        o_row[2*GW-1-(gx*2+sx)] = i_px[gx][sx];
                    end
                end
            end
            SCALE_EPX3: begin
                for (int gx = 0; gx < GW; gx++) begin
                    for (int sx = 0; sx < 3; sx++) begin
                        o_row[3*GW-1-(gx*3+sx)] = i_px[gx][sx];
                    end
                end
            end
            default: begin
                for (int gx = 0; gx < GW; gx++) begin
                    for (int sx = 0; sx < 4; sx++) begin
                        o_row[4*GW-1-(gx*4+sx)] = i_px[gx][sx];
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/binary_glyph_scale2x_scale3x_unit.sv =====
`default_nettype none

// Throughput: one output row per cycle while the job queue is not empty and the
//   sink takes each row; the single output register paced by the sub-row counter
//   sets this rate. A source row gives s output rows (s = effective scale 1..4),
//   a last row that flushes a pending row 2*s. The first row of a source row goes
//   from the releasing transfer into the job queue, then into the output register.
// Reset (synchronous, active low): scale 1, window empty, job queue and output empty.
module binary_glyph_scale2x_scale3x_unit #(
    parameter int unsigned GLYPH_WIDTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // scale_factor register
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    // source rows
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] row_bits (bit 7 leftmost)
    input  wire logic        s_axis_tlast,   // last_row
    // magnified rows
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] out_bits
    output logic             m_axis_tlast    // end_of_glyph
);
    import bgs_pkg::*;

    // pixels right of the glyph width read as zero
    localparam logic [ROW_W-1:0] ColMask =
        ROW_W'({ROW_W{1'b1}} << (ROW_W - GLYPH_WIDTH));

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    t_scale r_scale;
    t_scale w_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_MIN;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    assign w_scale = eff_scale(r_scale);

    // ---------------------------------------------------------------
    // row window: each transfer turns into zero, one or two row jobs
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] r_above, r_centre;
    logic             r_have;
    logic [ROW_W-1:0] w_row;
    logic             w_in_xfer;
    t_job             w_job_mid, w_job_fl, w_push0;
    logic [1:0]       w_npush;

    assign w_row     = s_axis_tdata & ColMask;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // pending centre row, now that its lower neighbor has arrived
    assign w_job_mid = '{above: r_above, centre: r_centre, below: w_row, final_row: 1'b0};
    // flush of the incoming row itself
    assign w_job_fl  = '{above: r_have ? r_centre : '0, centre: w_row, below: '0,
                         final_row: 1'b1};
    assign w_push0   = r_have ? w_job_mid : w_job_fl;
    assign w_npush   = w_in_xfer ? ({1'b0, r_have} + {1'b0, s_axis_tlast}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above  <= '0;
            r_centre <= '0;
            r_have   <= 1'b0;
        end else if (w_in_xfer) begin
            if (s_axis_tlast) begin
                r_above  <= '0;
                r_centre <= '0;
                r_have   <= 1'b0;
            end else begin
                r_above  <= r_have ? r_centre : '0;
                r_centre <= w_row;
                r_have   <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // job queue; a transfer needs room for two jobs
    // ---------------------------------------------------------------
    t_job             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt;
    logic             w_pop;
    t_job             w_job;

    assign s_axis_tready = (r_cnt <= (Q_AW+1)'(Q_DEPTH - 2));
    assign w_job         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_npush != 2'd0) begin
            r_q[r_wp] <= w_push0;
        end
        if (w_npush == 2'd2) begin
            r_q[r_wp + 1'b1] <= w_job_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(w_npush);
            r_rp  <= r_rp + Q_AW'(w_pop);
            r_cnt <= r_cnt + (Q_AW+1)'(w_npush) - (Q_AW+1)'(w_pop);
        end
    end

    // ---------------------------------------------------------------
    // sub-row sequencer, lanes and merge
    // ---------------------------------------------------------------
    logic [1:0]                 r_sy;
    logic                       w_last_sub, w_step;
    logic                       r_ov, r_olast;
    logic [OUT_W-1:0]           r_odata;
    logic [OUT_W-1:0]           w_row_out;
    logic [GLYPH_WIDTH-1:0][3:0] w_px;
    logic [ROW_W+1:0]           w_ext_a, w_ext_c, w_ext_b;
    t_sub                       w_sub;

    assign w_last_sub = ({1'b0, r_sy} == (w_scale - 3'd1));
    assign w_step     = (r_cnt != '0) && (!r_ov || m_axis_tready);
    assign w_pop      = w_step && w_last_sub;
    assign w_sub      = '{scale: w_scale, sy: r_sy};

    // zero pad on both sides for edge neighbors
    assign w_ext_a = {1'b0, w_job.above,  1'b0};
    assign w_ext_c = {1'b0, w_job.centre, 1'b0};
    assign w_ext_b = {1'b0, w_job.below,  1'b0};

    for (genvar gx = 0; gx < GLYPH_WIDTH; gx++) begin : g_lane
        bgs_lane u_lane (
            .i_above  (w_ext_a[ROW_W+1-gx -: 3]),
            .i_centre (w_ext_c[ROW_W+1-gx -: 3]),
            .i_below  (w_ext_b[ROW_W+1-gx -: 3]),
            .i_sub    (w_sub),
            .o_px     (w_px[gx])
        );
    end

    bgs_merge #(
        .GW (GLYPH_WIDTH)
    ) u_merge (
        .i_px    (w_px),
        .i_scale (w_scale),
        .o_row   (w_row_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sy <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_step) begin
                r_sy <= w_last_sub ? 2'd0 : r_sy + 2'd1;
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_odata <= w_row_out;
            r_olast <= w_job.final_row && w_last_sub;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("job queue count out of range");

    a_sy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_sy} < w_scale)
        else $error("sub-row counter beyond scale");

    a_window_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_above == '0 && r_centre == '0))
        else $error("window holds rows with no pending centre");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != '0) && (r_cnt + (Q_AW+1)'(w_npush) >= 1))
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

// ===== verif/binary_glyph_scale2x_scale3x_unit_test.sv =====
`timescale 1ns / 100ps

module binary_glyph_scale2x_scale3x_unit_test;

    import bgs_pkg::*;

    // Register values outside the 1..4 range that the package names
    localparam logic [2:0] SCALE_ZERO = 3'd0;   // reads as scale 1
    localparam logic [2:0] SCALE_SAT5 = 3'd5;   // 5..7 saturate to 4
    localparam logic [2:0] SCALE_SAT6 = 3'd6;
    localparam logic [2:0] SCALE_TOP  = 3'd7;

    localparam int RST_CYCLES  = 7;
    localparam int TAIL_CYCLES = 16;      // job queue depth plus pipe, with margin
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ROWS  = 17;      // 12 x 17 = 204 random source rows

    // One magnified row as it leaves the block
    typedef struct packed {
        logic [31:0] bits;
        logic        eog;
    } t_mag_row;

    // Directed rows: scale write (if set_scale), then the source row.
    // n_typed != 0 means the rows are spelled out here: n_typed copies of
    // typed_bits, end of glyph on the last one. Otherwise the predictor decides.
    typedef struct packed {
        logic        set_scale;
        logic [2:0]  scale;
        logic [7:0]  row;
        logic        last;
        logic [2:0]  n_typed;
        logic [31:0] typed_bits;
    } t_dir_row;

    localparam int DIR_ROWS = 24;

    t_dir_row dir_tab [DIR_ROWS] = '{
        // reset scale (1): single-row glyphs copy straight through
        '{1'b0, SCALE_MIN,  8'hFF, 1'b1, 3'd1, 32'h0000_00FF},
        '{1'b0, SCALE_MIN,  8'h00, 1'b1, 3'd1, 32'h0000_0000},
        // three-row glyph at scale 1; first row alone yields nothing
        '{1'b0, SCALE_MIN,  8'h81, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_MIN,  8'h42, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_MIN,  8'h24, 1'b1, 3'd0, 32'h0},
        // scale 2: isolated pixel stays a plain 2x2 block
        '{1'b1, SCALE_EPX2, 8'h10, 1'b1, 3'd2, 32'h0000_0300},
        // diagonal stroke, exercises the corner rules
        '{1'b0, SCALE_EPX2, 8'h80, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX2, 8'h40, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX2, 8'h20, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX2, 8'h10, 1'b1, 3'd0, 32'h0},
        // scale 3: edge pixels of a lone row, plain blocks
        '{1'b1, SCALE_EPX3, 8'h81, 1'b1, 3'd3, 32'h00E0_0007},
        // widening triangle then checkerboard
        '{1'b0, SCALE_EPX3, 8'h18, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX3, 8'h3C, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX3, 8'h7E, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX3, 8'hFF, 1'b1, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX3, 8'hAA, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_EPX3, 8'h55, 1'b1, 3'd0, 32'h0},
        // scale zero behaves as scale 1
        '{1'b1, SCALE_ZERO, 8'hA5, 1'b1, 3'd1, 32'h0000_00A5},
        // scale 7 saturates to 4
        '{1'b1, SCALE_TOP,  8'h80, 1'b1, 3'd4, 32'hF000_0000},
        // scale 4 full width, then a two-row glyph
        '{1'b1, SCALE_MAX,  8'hFF, 1'b1, 3'd4, 32'hFFFF_FFFF},
        '{1'b0, SCALE_MAX,  8'h01, 1'b0, 3'd0, 32'h0},
        '{1'b0, SCALE_MAX,  8'h80, 1'b1, 3'd0, 32'h0},
        // scales 5 and 6 saturate too
        '{1'b1, SCALE_SAT5, 8'h3C, 1'b1, 3'd4, 32'h00FF_FF00},
        '{1'b1, SCALE_SAT6, 8'hC3, 1'b1, 3'd4, 32'hFF00_00FF}
    };

    // Register settings for the random phases, extremes included
    logic [2:0] scale_plan [RAND_PHASES] = '{
        SCALE_EPX2, SCALE_EPX3, SCALE_MAX,  SCALE_MIN,
        SCALE_EPX3, SCALE_EPX2, SCALE_ZERO, SCALE_TOP,
        SCALE_SAT5, SCALE_SAT6, SCALE_EPX3, SCALE_EPX2
    };

    // ---------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] row_bits (bit 7 leftmost)
    logic        s_axis_tlast  = 1'b0;   // last_row
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] out_bits
    logic        m_axis_tlast;           // end_of_glyph

    binary_glyph_scale2x_scale3x_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor state: register copy and the three-row window
    // ---------------------------------------------------------------------
    logic [2:0] scale_reg  = SCALE_MIN;
    logic [7:0] win_above  = '0;
    logic [7:0] win_centre = '0;
    bit         win_full   = 1'b0;

    t_mag_row   fresh_rows [$];    // rows produced by the latest transfer
    t_mag_row   pending_rows [$];  // rows still owed by the block

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatches   = 0;
    int cycle_count  = 0;

    // Number of output rows per source row for a register value
    function automatic int unsigned sub_rows(input logic [2:0] v);
        case (v)
            SCALE_ZERO:                     return 1;
            SCALE_SAT5, SCALE_SAT6, SCALE_TOP: return 4;
            default:                        return int'(v);
        endcase
    endfunction

    // Pixel fetch; anything off the glyph reads as background
    function automatic bit glyph_px(input logic [7:0] r, input int x);
        if (x < 0 || x > 7) return 1'b0;
        return r[7 - x];
    endfunction

    // Magnify centre row c with neighbors a (above) and b (below)
    function automatic void magnify_row(input logic [7:0] a, input logic [7:0] c,
                                        input logic [7:0] b, input bit fin);
        int unsigned s;
        bit          smooth;
        bit          o [16];
        logic [31:0] rows [4];
        bit          A, B, C, D, E, F, G, H, I;
        bit          db, bf, hd, fh;
        t_mag_row    r;
        s      = sub_rows(scale_reg);
        smooth = (s == 2 || s == 3);
        for (int k = 0; k < 4; k++) rows[k] = '0;
        for (int gx = 0; gx < 8; gx++) begin
            E = glyph_px(c, gx);
            for (int k = 0; k < 16; k++) o[k] = E;
            if (smooth) begin
                A = glyph_px(a, gx - 1);
                B = glyph_px(a, gx);
                C = glyph_px(a, gx + 1);
                D = glyph_px(c, gx - 1);
                F = glyph_px(c, gx + 1);
                G = glyph_px(b, gx - 1);
                H = glyph_px(b, gx);
                I = glyph_px(b, gx + 1);
                db = (D == B) && (D != H) && (B != F);
                bf = (B == F) && (B != D) && (F != H);
                hd = (H == D) && (H != F) && (D != B);
                fh = (F == H) && (F != B) && (H != D);
                if (s == 2) begin
                    if (db) o[0] = D;
                    if (bf) o[1] = F;
                    if (hd) o[2] = D;
                    if (fh) o[3] = F;
                end else begin
                    if (db) o[0] = D;
                    if ((db && E != C) || (bf && E != A)) o[1] = B;
                    if (bf) o[2] = F;
                    if ((hd && E != A) || (db && E != G)) o[3] = D;
                    if ((bf && E != I) || (fh && E != C)) o[5] = F;
                    if (hd) o[6] = D;
                    if ((fh && E != G) || (hd && E != I)) o[7] = H;
                    if (fh) o[8] = F;
                end
            end
            // leftmost pixel lands in the highest used bit
            for (int sy = 0; sy < s; sy++)
                for (int sx = 0; sx < s; sx++)
                    if (o[sy * s + sx]) rows[sy][s * 8 - 1 - (gx * s + sx)] = 1'b1;
        end
        for (int sy = 0; sy < s; sy++) begin
            r.bits = rows[sy];
            r.eog  = fin && (sy == s - 1);
            fresh_rows.push_back(r);
        end
    endfunction

    // One accepted source row: release the pending centre row, slide the
    // window, and flush everything on the bottom row of the glyph.
    function automatic void advance_window(input logic [7:0] row, input bit last);
        fresh_rows.delete();
        if (win_full) begin
            magnify_row(win_above, win_centre, row, 1'b0);
            win_above = win_centre;
        end else begin
            win_above = '0;
        end
        win_centre = row;
        win_full   = 1'b1;
        if (last) begin
            magnify_row(win_above, win_centre, 8'h00, 1'b1);
            win_above  = '0;
            win_centre = '0;
            win_full   = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Source side. Called and returns at a falling edge; tvalid stays up
    // between back-to-back transfers and drops only for an idle gap.
    // ---------------------------------------------------------------------
    task automatic send_row(input logic [7:0] row, input logic last,
                            input int n_typed, input logic [31:0] typed_bits);
        t_mag_row r;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_window(row, last);
        if (n_typed != 0) begin
            for (int k = 0; k < n_typed; k++) begin
                r.bits = typed_bits;
                r.eog  = (k == n_typed - 1);
                pending_rows.push_back(r);
            end
        end else begin
            foreach (fresh_rows[k]) pending_rows.push_back(fresh_rows[k]);
        end
        @(negedge i_clk);
    endtask

    // Hold off the source until every owed row is out, then wait out the tail
    // (a first row of a glyph may still sit in the window with nothing owed).
    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_scale(input logic [2:0] v);
        settle(TAIL_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        scale_reg    = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mixed row shapes: uniform, sparse, dense, single pixel
    function automatic logic [7:0] pick_row();
        case ($urandom_range(3))
            0:       return 8'($urandom);
            1:       return 8'($urandom & $urandom);
            2:       return 8'($urandom | $urandom);
            default: return 8'h01 << $urandom_range(7);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Sink side: random backpressure, then in-order compare on each transfer
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_mag_row want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected row: expected none, got bits=%h eog=%b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_rows.pop_front();
                if (m_axis_tdata !== want.bits) begin
                    mismatches++;
                    $display("%0t: out_bits mismatch: expected %h, got %h",
                             $time, want.bits, m_axis_tdata);
                end
                if (m_axis_tlast !== want.eog) begin
                    mismatches++;
                    $display("%0t: end_of_glyph mismatch: expected %b, got %b",
                             $time, want.eog, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        int made;
        int height;
        bit last;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, light source gaps and heavy sink stalls
        src_idle_pct = 16;
        snk_idle_pct = 64;
        for (int n = 0; n < DIR_ROWS; n++) begin
            if (dir_tab[n].set_scale) write_scale(dir_tab[n].scale);
            send_row(dir_tab[n].row, dir_tab[n].last,
                     int'(dir_tab[n].n_typed), dir_tab[n].typed_bits);
        end

        // random glyphs; each phase ends on a bottom row so the window is
        // empty before the next register write
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p / 4)
                0: begin
                    src_idle_pct = 16;
                    snk_idle_pct = 64;
                end
                1: begin
                    src_idle_pct = 64;
                    snk_idle_pct = 16;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            write_scale(scale_plan[p]);
            made = 0;
            while (made < PHASE_ROWS) begin
                height = $urandom_range(1, 6);
                for (int r = 0; r < height && made < PHASE_ROWS; r++) begin
                    last = (r == height - 1) || (made == PHASE_ROWS - 1);
                    // occasional full hold-off, mid-glyph included
                    if (made != 0 && $urandom_range(19) == 0) settle(0);
                    send_row(pick_row(), last, 0, 32'h0);
                    made++;
                end
            end
        end

        settle(TAIL_CYCLES);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bgs_pkg.sv
hw/rtl/bgs_lane.sv
hw/rtl/bgs_merge.sv
hw/rtl/binary_glyph_scale2x_scale3x_unit.sv
verif/binary_glyph_scale2x_scale3x_unit_test.sv
